[sv/pfr_pkg.sv]
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared types and constants for the path frame receiver.
// ----------------------------------------------------------------------------
package pfr_pkg;

    localparam int unsigned WORDS_PER_NODE = 5;
    localparam int unsigned POS_W          = 4;
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned WORD_W         = 32;
    localparam int unsigned PARTIAL_W      = 24;
    localparam int unsigned OUT_TDATA_W    = 48;

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'd147;

    typedef enum logic [1:0] {
        PHASE_IDLE    = 2'd0,
        PHASE_LENGTH  = 2'd1,
        PHASE_PAYLOAD = 2'd2
    } pfr_phase_t;

    typedef struct packed {
        logic                word_valid;
        logic [BYTE_W-1:0]   node_index;
        logic [POS_W-1:0]    word_index;
        logic [WORD_W-1:0]   word_value;
        logic                frame_done;
    } pfr_result_t;

endpackage

[sv/pfr_parser.sv]
// ----------------------------------------------------------------------------
// pfr_parser
// Frame parse state and the per-byte step: sync, length, word assembly.
// ----------------------------------------------------------------------------
module pfr_parser (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step_en,
    input  logic [7:0]                rx_byte,
    input  logic [7:0]                sync_byte,
    output logic                      res_valid,
    output pfr_pkg::pfr_result_t      res
);
    import pfr_pkg::*;

    pfr_phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]       frame_length_reg, frame_length_next;
    logic [1:0]              byte_count_reg, byte_count_next;
    logic [POS_W-1:0]        word_pos_reg, word_pos_next;
    logic [BYTE_W-1:0]       node_count_reg, node_count_next;
    logic [PARTIAL_W-1:0]    partial_reg, partial_next;
    logic [POS_W:0]          pos_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PHASE_IDLE;
            frame_length_reg <= '0;
            byte_count_reg   <= '0;
            word_pos_reg     <= '0;
            node_count_reg   <= '0;
            partial_reg      <= '0;
        end else if (step_en) begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            byte_count_reg   <= byte_count_next;
            word_pos_reg     <= word_pos_next;
            node_count_reg   <= node_count_next;
            partial_reg      <= partial_next;
        end
    end

    assign pos_inc = {1'b0, word_pos_reg} + (POS_W+1)'(1);

    always_comb begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        byte_count_next   = byte_count_reg;
        word_pos_next     = word_pos_reg;
        node_count_next   = node_count_reg;
        partial_next      = partial_reg;
        res               = '0;

        unique case (phase_reg)
            PHASE_LENGTH: begin
                frame_length_next = rx_byte;
                byte_count_next   = '0;
                word_pos_next     = '0;
                node_count_next   = '0;
                phase_next        = PHASE_PAYLOAD;
            end
            PHASE_PAYLOAD: begin
                unique case (byte_count_reg)
                    2'd0: partial_next[7:0]   = rx_byte;
                    2'd1: partial_next[15:8]  = rx_byte;
                    2'd2: partial_next[23:16] = rx_byte;
                    default: begin
                        res.word_valid = 1'b1;
                        res.node_index = node_count_reg;
                        res.word_index = word_pos_reg;
                        res.word_value = {rx_byte, partial_reg};
                        // node advances after the last word of the node
                        if (pos_inc >= (POS_W+1)'(WORDS_PER_NODE)) begin
                            word_pos_next   = '0;
                            node_count_next = node_count_reg + 8'd1;
                        end else begin
                            word_pos_next   = pos_inc[POS_W-1:0];
                        end
                    end
                endcase
                byte_count_next = byte_count_reg + 2'd1;
                if (node_count_next == frame_length_reg) begin
                    res.frame_done = 1'b1;
                    phase_next     = PHASE_IDLE;
                end
            end
            default: begin
                phase_next = (rx_byte == sync_byte) ? PHASE_LENGTH : PHASE_IDLE;
            end
        endcase
    end

    assign res_valid = res.word_valid | res.frame_done;

endmodule

[sv/pfr_out_reg.sv]
// ----------------------------------------------------------------------------
// pfr_out_reg
// Result register driving the master stream.
// ----------------------------------------------------------------------------
module pfr_out_reg (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load_valid,
    input  pfr_pkg::pfr_result_t      load_res,
    output logic                      load_ready,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [47:0]               m_axis_tdata,
    output logic                      m_axis_tuser,
    output logic                      m_axis_tlast
);
    import pfr_pkg::*;

    logic         valid_reg;
    pfr_result_t  res_reg;

    assign load_ready = !valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_ready) begin
            valid_reg <= load_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_ready && load_valid) begin
            res_reg <= load_res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {4'd0, res_reg.word_value, res_reg.word_index,
                            res_reg.node_index};
    assign m_axis_tuser  = res_reg.word_valid;
    assign m_axis_tlast  = res_reg.frame_done;

endmodule

[sv/path_frame_receiver.sv]
// ----------------------------------------------------------------------------
// path_frame_receiver
// Length-prefixed frame receiver: sync byte, node count, then 32-bit words.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle on the slave stream and never stalls it
// except when the result register is full and the downstream holds tready
// low. A byte passes an input register, the parse step, and the result
// register before its word appears on the master side.
// While idle the block waits for the sync byte; the next byte is the frame
// length in nodes; payload bytes are packed four to a word, first byte in
// the low bits, and each word leaves with its node number and its position
// in the node (five words per node). A result with tlast set ends the frame;
// with a zero length the first payload byte ends it with no word (tuser low,
// tdata zero). Bytes that complete no word and no frame produce no result.
// ----------------------------------------------------------------------------
module path_frame_receiver (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata,     // sync_byte
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // [7:0] rx_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,  // [7:0] node_index, [11:8] word_index,
                                        // [43:12] word_value, [47:44] zero
    output logic         m_axis_tuser,  // word_valid
    output logic         m_axis_tlast   // frame_done
);
    import pfr_pkg::*;

    logic [BYTE_W-1:0]  sync_byte_reg;
    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               res_valid;
    pfr_result_t        res;
    logic               out_ready;
    logic               step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_byte_reg <= SYNC_RESET;
        end else if (cfg_we) begin
            sync_byte_reg <= cfg_wdata;
        end
    end

    // byte leaves the input register when its result (if any) can be stored
    assign step          = in_valid_reg && (!res_valid || out_ready);
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    pfr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step),
        .rx_byte   (in_byte_reg),
        .sync_byte (sync_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    pfr_out_reg u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load_valid    (step && res_valid),
        .load_res      (res),
        .load_ready    (out_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // a result without a word can only be the end of a frame
    a_noword_is_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("result without word and without frame done");

    a_noword_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 48'd0)
        else $error("frame-done result carries nonzero data");

    a_word_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |->
            {1'b0, m_axis_tdata[11:8]} < (POS_W+1)'(WORDS_PER_NODE))
        else $error("word position beyond words per node");
`endif

endmodule
